FILE: hdl/ums_pkg.sv
package ums_pkg;

	// frame geometry limits
	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 4096;
	localparam int MinSize   = 5;

	localparam int ColW    = $clog2(MaxWidth);
	localparam int WidthW  = $clog2(MaxWidth) + 1;
	localparam int HeightW = $clog2(MaxHeight) + 1;
	localparam int GainW   = 10;
	localparam int CfgW    = 13;

	// line store: one word per column, one byte lane per buffered row
	localparam int Lanes = 4;
	localparam int LaneW = $clog2(Lanes);

	// box mean over 25 pixels: floor((sum + 12) / 25) by reciprocal
	localparam int SumW      = 13;
	localparam int RowSumW   = 11;
	localparam int MeanBias  = 12;
	localparam int MeanRecip = 5243;
	localparam int MeanShift = 17;
	localparam int ProdW     = 2 * SumW;

	// front-to-back queue
	localparam int QueueDepth = 8;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCountW    = $clog2(QueueDepth) + 1;

	// register defaults
	localparam logic [WidthW-1:0]  WidthReset  = WidthW'(512);
	localparam logic [HeightW-1:0] HeightReset = HeightW'(512);
	localparam logic [GainW-1:0]   GainReset   = GainW'(77);

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_GAIN   = 2'd2
	} ums_reg_t;

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       drain;
	} ums_in_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_last;
	} ums_out_t;

	// one classified result on its way from front to back
	typedef struct packed {
		logic [SumW-1:0] sum;
		logic [7:0]      centre;
		logic [7:0]      border;
		logic            interior;
		logic            last;
	} ums_item_t;

endpackage

FILE: hdl/unsharp_mask_sharpener.sv
// order: a beat's result passes s1, s2, s3, the queue, b1, b2 and the output register;
// results trail the pixel stream by 2*width+2 pixels
// throughput: one beat per cycle when not stalled, set by the line store and the queue
// reset: counters, window and settings return to defaults; the line store is not
// cleared and needs no clearing pass
module unsharp_mask_sharpener
	import ums_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_stall,
	input  ums_in_t         pix_data,
	output logic            res_valid,
	input  logic            res_stall,
	output ums_out_t        res_data,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_wdata
);

	logic [WidthW-1:0]  width_q, w;
	logic [HeightW-1:0] height_q, h;
	logic [GainW-1:0]   gain_q;

	logic               accept, push, pop, nonempty;
	logic [1:0]         inflight;
	logic [QCountW-1:0] q_count;
	ums_item_t          push_item, pop_item;

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
			gain_q   <= GainReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_wdata[WidthW-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[HeightW-1:0];
				REG_GAIN:   gain_q   <= cfg_wdata[GainW-1:0];
				default: ;
			endcase
		end
	end

	// clamp sizes to the supported range
	always_comb begin
		if (width_q < WidthW'(MinSize))
			w = WidthW'(MinSize);
		else if (width_q > WidthW'(MaxWidth))
			w = WidthW'(MaxWidth);
		else
			w = width_q;
		if (height_q < HeightW'(MinSize))
			h = HeightW'(MinSize);
		else if (height_q > HeightW'(MaxHeight))
			h = HeightW'(MaxHeight);
		else
			h = height_q;
	end

	// hold input while the queue could not take every beat in flight
	assign pix_stall = ((QCountW+1)'(q_count) + (QCountW+1)'(inflight)) >=
		(QCountW+1)'(QueueDepth);
	assign accept = pix_valid && !pix_stall;

	ums_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.beat     (pix_data),
		.w        (w),
		.h        (h),
		.push     (push),
		.item     (push_item),
		.inflight (inflight)
	);

	ums_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (push_item),
		.pop      (pop),
		.rdata    (pop_item),
		.nonempty (nonempty),
		.count    (q_count)
	);

	ums_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (nonempty),
		.item      (pop_item),
		.pop       (pop),
		.gain      (gain_q),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCountW'(QueueDepth))
		else $error("queue over depth");

	// no push into a full queue unless a pop frees a slot
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && q_count == QCountW'(QueueDepth)))
		else $error("push into full queue");

	// an input that is not stalled leaves room for everything in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		!pix_stall |-> (q_count + QCountW'(inflight)) < QCountW'(QueueDepth))
		else $error("credit accounting broken");

endmodule

FILE: hdl/ums_front.sv
module ums_front
	import ums_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  ums_in_t            beat,
	input  logic [WidthW-1:0]  w,
	input  logic [HeightW-1:0] h,
	output logic               push,
	output ums_item_t          item,
	output logic [1:0]         inflight
);

	// position counters
	logic [ColW-1:0]    in_col_q, out_col_q;
	logic [HeightW-1:0] in_row_q, out_row_q;

	logic               in_phase, do_pix, has_res, started, interior, last;
	logic               in_wrap, out_wrap, fwd;
	logic [HeightW-1:0] out_row_nx;

	// line store and window
	logic [Lanes*8-1:0] mem [MaxWidth];
	logic [Lanes*8-1:0] rd_in_q, rd_out_q;
	logic [7:0]         win_q [5][5];

	// stage registers
	logic             s1_v, s1_shift, s1_fwd, s1_interior, s1_last;
	logic [7:0]       s1_pix;
	logic [LaneW-1:0] s1_slot, s1_oslot;

	logic       s2_v, s2_interior, s2_last;
	logic [7:0] s2_border;

	logic               s3_v, s3_interior, s3_last;
	logic [7:0]         s3_border, s3_centre;
	logic [RowSumW-1:0] s3_rsum [5];

	// classify the beat
	always_comb begin
		in_phase = in_row_q < h;
		do_pix   = accept && in_phase && !beat.drain;
		started  = (in_row_q > HeightW'(2)) ||
			(in_row_q == HeightW'(2) && in_col_q >= ColW'(2));
		has_res  = accept && (in_phase ? (!beat.drain && started) : 1'b1);
		interior = in_phase && out_row_q >= HeightW'(2) &&
			({1'b0, out_row_q} + (HeightW+1)'(2)) < {1'b0, h} &&
			out_col_q >= ColW'(2) &&
			({1'b0, out_col_q} + WidthW'(2)) < w;
		in_wrap    = ({1'b0, in_col_q} + WidthW'(1)) >= w;
		out_wrap   = ({1'b0, out_col_q} + WidthW'(1)) >= w;
		out_row_nx = out_wrap ? out_row_q + HeightW'(1) : out_row_q;
		last       = out_row_nx >= h;
		fwd        = do_pix && out_col_q == in_col_q &&
			out_row_q[LaneW-1:0] == in_row_q[LaneW-1:0];
	end

	// counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (has_res && last) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (do_pix) begin
				in_col_q <= in_wrap ? '0 : in_col_q + ColW'(1);
				if (in_wrap)
					in_row_q <= in_row_q + HeightW'(1);
			end
			if (has_res) begin
				out_col_q <= out_wrap ? '0 : out_col_q + ColW'(1);
				out_row_q <= out_row_nx;
			end
		end
	end

	// line store: byte write for the newest row, two word reads
	always_ff @(posedge clk) begin
		if (do_pix)
			mem[in_col_q][8*in_row_q[LaneW-1:0] +: 8] <= beat.pixel_in;
		rd_in_q  <= mem[in_col_q];
		rd_out_q <= mem[out_col_q];
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v     <= 1'b0;
			s1_shift <= 1'b0;
		end else begin
			s1_v     <= has_res;
			s1_shift <= do_pix;
		end
	end

	always_ff @(posedge clk) begin
		s1_pix      <= beat.pixel_in;
		s1_slot     <= in_row_q[LaneW-1:0];
		s1_oslot    <= out_row_q[LaneW-1:0];
		s1_fwd      <= fwd;
		s1_interior <= interior;
		s1_last     <= last;
	end

	// window shift with the column just read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 5; k++)
				for (int j = 0; j < 5; j++)
					win_q[k][j] <= '0;
		end else if (s1_shift) begin
			for (int k = 0; k < 5; k++)
				for (int j = 0; j < 4; j++)
					win_q[k][j] <= win_q[k][j+1];
			// lane index wraps modulo the lane count
			for (int k = 0; k < 4; k++)
				win_q[k][4] <= rd_in_q[8*LaneW'(s1_slot + LaneW'(k)) +: 8];
			win_q[4][4] <= s1_pix;
		end
	end

	// stage 2: border value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v <= 1'b0;
		else
			s2_v <= s1_v;
	end

	always_ff @(posedge clk) begin
		s2_border   <= s1_fwd ? s1_pix : rd_out_q[8*s1_oslot +: 8];
		s2_interior <= s1_interior;
		s2_last     <= s1_last;
	end

	// stage 3: row sums of the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s3_v <= 1'b0;
		else
			s3_v <= s2_v;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 5; k++)
			s3_rsum[k] <= RowSumW'(win_q[k][0]) + RowSumW'(win_q[k][1]) +
				RowSumW'(win_q[k][2]) + RowSumW'(win_q[k][3]) + RowSumW'(win_q[k][4]);
		s3_centre   <= win_q[2][2];
		s3_border   <= s2_border;
		s3_interior <= s2_interior;
		s3_last     <= s2_last;
	end

	// total and hand off to the queue
	always_comb begin
		push          = s3_v;
		item.sum      = SumW'(s3_rsum[0]) + SumW'(s3_rsum[1]) + SumW'(s3_rsum[2]) +
			SumW'(s3_rsum[3]) + SumW'(s3_rsum[4]) + SumW'(MeanBias);
		item.centre   = s3_centre;
		item.border   = s3_border;
		item.interior = s3_interior;
		item.last     = s3_last;
		inflight      = 2'({1'b0, s1_v} + {1'b0, s2_v} + {1'b0, s3_v});
	end

endmodule

FILE: hdl/ums_queue.sv
module ums_queue
	import ums_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ums_item_t          wdata,
	input  logic               pop,
	output ums_item_t          rdata,
	output logic               nonempty,
	output logic [QCountW-1:0] count
);

	ums_item_t         buf_q [QueueDepth];
	logic [QPtrW-1:0]  wr_q, rd_q;
	logic [QCountW-1:0] count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPtrW'(1);
			if (pop)
				rd_q <= rd_q + QPtrW'(1);
			if (push && !pop)
				count_q <= count_q + QCountW'(1);
			else if (pop && !push)
				count_q <= count_q - QCountW'(1);
		end
	end

	assign rdata    = buf_q[rd_q];
	assign nonempty = count_q != '0;
	assign count    = count_q;

endmodule

FILE: hdl/ums_back.sv
module ums_back
	import ums_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  ums_item_t        item,
	output logic             pop,
	input  logic [GainW-1:0] gain,
	output logic             res_valid,
	input  logic             res_stall,
	output ums_out_t         res_data
);

	logic             b1_v, b1_interior, b1_last;
	logic [ProdW-1:0] b1_prod;
	logic [7:0]       b1_centre, b1_border;

	logic               b2_v, b2_interior, b2_last;
	logic signed [20:0] b2_gprod;
	logic [7:0]         b2_centre, b2_border;

	logic               out_v_q;
	ums_out_t           out_q;

	logic               out_adv, b2_adv, b1_adv;
	logic [8:0]         mean;
	logic signed [9:0]  diff;
	logic signed [21:0] num;
	logic [7:0]         sharp;

	// stage advance chain
	always_comb begin
		out_adv = !out_v_q || !res_stall;
		b2_adv  = !b2_v || out_adv;
		b1_adv  = !b1_v || b2_adv;
		pop     = avail && b1_adv;
	end

	// mean, difference and rounded clamp
	always_comb begin
		mean = b1_prod[MeanShift +: 9];
		diff = $signed({2'b00, b1_centre}) - $signed({1'b0, mean});
		num  = $signed({6'd0, b2_centre, 8'h80}) + 22'(b2_gprod);
		if (num[21])
			sharp = 8'd0;
		else if (num[20:16] != '0)
			sharp = 8'd255;
		else
			sharp = num[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v    <= 1'b0;
			b2_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (b1_adv)
				b1_v <= pop;
			if (b2_adv)
				b2_v <= b1_v;
			if (out_adv)
				out_v_q <= b2_v;
		end
	end

	// stage 1: reciprocal multiply for the mean
	always_ff @(posedge clk) begin
		if (b1_adv) begin
			b1_prod     <= ProdW'(item.sum) * ProdW'(MeanRecip);
			b1_centre   <= item.centre;
			b1_border   <= item.border;
			b1_interior <= item.interior;
			b1_last     <= item.last;
		end
	end

	// stage 2: gain times high-pass
	always_ff @(posedge clk) begin
		if (b2_adv) begin
			b2_gprod    <= $signed({1'b0, gain}) * diff;
			b2_centre   <= b1_centre;
			b2_border   <= b1_border;
			b2_interior <= b1_interior;
			b2_last     <= b1_last;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_q.pixel_out  <= b2_interior ? sharp : b2_border;
			out_q.frame_last <= b2_last;
		end
	end

	assign res_valid = out_v_q;
	assign res_data  = out_q;

endmodule
